### src/mctm_pkg.sv
// Shared types and constants of the clock-pulse tempo meter.
package mctm_pkg;

    // Fixed field widths
    localparam int PPB_W = 8;
    localparam int MIT_W = 26;

    // Register reset values
    localparam logic [PPB_W-1:0] PPB_RESET = 8'd24;
    localparam logic [MIT_W-1:0] MIT_RESET = 26'd60000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PPB = 1'b0,
        CFG_MIT = 1'b1
    } t_cfg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;       // input pulse transfer
        logic push;          // push latched interval into window
        logic res_clear;     // window still filling: all-zero result
        logic avg_load;      // average by shift
        logic div_start;     // start the divider
        logic div_sel_tempo; // divider operands: 1 tempo, 0 average
        logic avg_take;      // average from divider quotient
        logic zero_set;      // zero average result
        logic tempo_go;      // nonzero average, tempo under way
        logic tempo_take;    // tempo from divider quotient
        logic out_load;      // load output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic measure;   // current pulse ends a measurement
        logic fill_next; // window full after the pending push
        logic wd_pow2;   // window depth is a power of two
        logic avg_zero;  // averaged beat length is zero
        logic div_done;  // divider quotient ready
        logic out_free;  // output register can take a result
    } t_dp_stat;

endpackage

### src/midi_clock_tempo_meter.sv
// Top level of the clock-pulse tempo meter.
// Each input transfer is one clock pulse with its timestamp. A pulse that does
// not end a measurement is taken and counted. The pulse whose count equals
// pulses_per_beat pushes the beat interval into the window and yields one
// result: with a power-of-two window depth the average is a shift, otherwise
// it comes from the divider, as does the tempo. D = max(TIME_WIDTH +
// log2(WINDOW_DEPTH), 26) is the number of steps of the shared shift-subtract
// divider (one quotient bit per cycle); D = 34 at the defaults. Until the
// window holds WINDOW_DEPTH intervals the result is all zero; afterwards it
// carries the average beat length and the tempo, or zero_beat when the
// average is zero. A finished result waits in an output register while the
// next pulses are taken. Configuration writes are always accepted and should
// be made while the block is idle.
module midi_clock_tempo_meter
    import mctm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_index,
    input  logic [MIT_W-1:0]                      i_cfg_data,
    // pulse input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((TIME_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // pulse_time
    // result output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((TIME_WIDTH+MIT_W+7)/8)*8-1:0] m_axis_tdata,  // beat_ticks, tempo_bpm
    output logic [1:0]                            m_axis_tuser   // window_full, zero_beat
);

    localparam int OUT_W = ((TIME_WIDTH + MIT_W + 7) / 8) * 8;

    t_dp_cmd               cmd;
    t_dp_stat              stat;
    logic [TIME_WIDTH-1:0] beat_ticks;
    logic [MIT_W-1:0]      tempo_bpm;
    logic                  window_full;
    logic                  zero_beat;

    mctm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mctm_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pulse_time  (s_axis_tdata[TIME_WIDTH-1:0]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_beat_ticks  (beat_ticks),
        .o_tempo_bpm   (tempo_bpm),
        .o_window_full (window_full),
        .o_zero_beat   (zero_beat)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = OUT_W'({tempo_bpm, beat_ticks});
    assign m_axis_tuser = {zero_beat, window_full};

endmodule

### src/mctm_ctrl.sv
// Sequencing controller of the tempo meter.
module mctm_ctrl
    import mctm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PUSH = 7'b0000010,
        S_AVG  = 7'b0000100,
        S_AVGW = 7'b0001000,
        S_CHK  = 7'b0010000,
        S_TMPW = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.measure) n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_stat.fill_next) begin
                    n_state = S_AVG;
                end else begin
                    o_cmd.res_clear = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_AVG: begin
                if (i_stat.wd_pow2) begin
                    o_cmd.avg_load = 1'b1;
                    n_state        = S_CHK;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_AVGW;
                end
            end
            S_AVGW: begin
                if (i_stat.div_done) begin
                    o_cmd.avg_take = 1'b1;
                    n_state        = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.avg_zero) begin
                    o_cmd.zero_set = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.div_start     = 1'b1;
                    o_cmd.div_sel_tempo = 1'b1;
                    o_cmd.tempo_go      = 1'b1;
                    n_state             = S_TMPW;
                end
            end
            S_TMPW: begin
                if (i_stat.div_done) begin
                    o_cmd.tempo_take = 1'b1;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### src/mctm_div.sv
// Shift-subtract divider, one quotient bit per cycle.
module mctm_div #(
    parameter int DIVIDEND_W = 34,
    parameter int DIVISOR_W  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic                  o_done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  q_bit;

    // One restoring step
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
    end

    // Control: busy, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], q_bit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

### src/mctm_dp.sv
// Datapath: registers, pulse counter, interval window, divider, output stage.
module mctm_dp
    import mctm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [MIT_W-1:0]      i_cfg_data,
    // input pulse
    input  logic [TIME_WIDTH-1:0] i_pulse_time,
    // controller link
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    // output stage
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [TIME_WIDTH-1:0] o_beat_ticks,
    output logic [MIT_W-1:0]      o_tempo_bpm,
    output logic                  o_window_full,
    output logic                  o_zero_beat
);

    localparam int LOG_WD  = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = TIME_WIDTH + LOG_WD;
    localparam int HELD_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int DIV_W   = (SUM_W > MIT_W) ? SUM_W : MIT_W;
    localparam bit WD_POW2 = ((WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0);

    // Configuration registers
    logic [PPB_W-1:0]      r_ppb;
    logic [MIT_W-1:0]      r_mit;

    // Measurement state
    logic [PPB_W-1:0]      r_count;
    logic [TIME_WIDTH-1:0] r_start;
    logic [TIME_WIDTH-1:0] r_interval;
    logic [TIME_WIDTH-1:0] r_win [WINDOW_DEPTH];
    logic [HELD_W-1:0]     r_held;
    logic [SUM_W-1:0]      r_sum;

    // Result registers
    logic [TIME_WIDTH-1:0] r_avg;
    logic [MIT_W-1:0]      r_tempo;
    logic                  r_full;
    logic                  r_zero;

    // Output register
    logic                  r_out_valid;
    logic [TIME_WIDTH-1:0] r_out_beat;
    logic [MIT_W-1:0]      r_out_tempo;
    logic                  r_out_full;
    logic                  r_out_zero;

    logic [PPB_W:0]        cnt_inc;
    logic [PPB_W-1:0]      n_count;
    logic                  win_full;
    logic [SUM_W-1:0]      n_sum;
    logic                  out_free;
    logic [DIV_W-1:0]      div_dividend;
    logic [TIME_WIDTH-1:0] div_divisor;
    logic [DIV_W-1:0]      div_quotient;
    logic                  div_done;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppb <= PPB_RESET;
            r_mit <= MIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PPB: r_ppb <= i_cfg_data[PPB_W-1:0];
                CFG_MIT: r_mit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pulse counter wraps past pulses_per_beat
    always_comb begin
        cnt_inc = {1'b0, r_count} + 1'b1;
        n_count = (cnt_inc > {1'b0, r_ppb}) ? '0 : cnt_inc[PPB_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_start <= '0;
        end else if (i_cmd.capture) begin
            r_count <= n_count;
            if (r_count == '0) r_start <= i_pulse_time;
        end
    end

    // Interval, zero when the start stamp is captured by this same pulse
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_interval <= (r_count == '0) ? '0 : i_pulse_time - r_start;
        end
    end

    // Running window sum: add newest, drop oldest once full
    assign win_full = (r_held == HELD_W'(WINDOW_DEPTH));

    always_comb begin
        n_sum = r_sum + SUM_W'(r_interval);
        if (win_full) n_sum = n_sum - SUM_W'(r_win[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_sum  <= '0;
        end else if (i_cmd.push) begin
            r_sum <= n_sum;
            if (!win_full) r_held <= r_held + 1'b1;
        end
    end

    // Window shift line, oldest at entry 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WINDOW_DEPTH-1] <= r_interval;
        end
    end

    // Divider operand select
    always_comb begin
        if (i_cmd.div_sel_tempo) begin
            div_dividend = DIV_W'(r_mit);
            div_divisor  = r_avg;
        end else begin
            div_dividend = DIV_W'(r_sum);
            div_divisor  = TIME_WIDTH'(WINDOW_DEPTH);
        end
    end

    mctm_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (TIME_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_done     (div_done)
    );

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clear) begin
            r_avg   <= '0;
            r_tempo <= '0;
            r_full  <= 1'b0;
            r_zero  <= 1'b0;
        end
        if (i_cmd.avg_load) r_avg <= r_sum[SUM_W-1 -: TIME_WIDTH];
        if (i_cmd.avg_take) r_avg <= div_quotient[TIME_WIDTH-1:0];
        if (i_cmd.zero_set) begin
            r_tempo <= '0;
            r_full  <= 1'b0;
            r_zero  <= 1'b1;
        end
        if (i_cmd.tempo_go) begin
            r_full <= 1'b1;
            r_zero <= 1'b0;
        end
        if (i_cmd.tempo_take) r_tempo <= div_quotient[MIT_W-1:0];
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_beat  <= r_avg;
            r_out_tempo <= r_tempo;
            r_out_full  <= r_full;
            r_out_zero  <= r_zero;
        end
    end

    // Status to controller
    always_comb begin
        o_stat.measure   = (r_count == r_ppb);
        o_stat.fill_next = (r_held >= HELD_W'(WINDOW_DEPTH - 1));
        o_stat.wd_pow2   = WD_POW2;
        o_stat.avg_zero  = (r_avg == '0);
        o_stat.div_done  = div_done;
        o_stat.out_free  = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_beat_ticks  = r_out_beat;
    assign o_tempo_bpm   = r_out_tempo;
    assign o_window_full = r_out_full;
    assign o_zero_beat   = r_out_zero;

endmodule

### src/mctm_checker.sv
// Port-level checker of the tempo meter and its bind.
module mctm_checker
    import mctm_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((TIME_WIDTH+MIT_W+7)/8)*8-1:0] m_axis_tdata,
    input logic [1:0]                            m_axis_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Full and zero flags never together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("window_full and zero_beat both set");

    // No tempo without a full window
    a_tempo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0]
            |-> m_axis_tdata[TIME_WIDTH+MIT_W-1:TIME_WIDTH] == '0)
        else $error("tempo reported without full window");

    // Zero flag only with zero beat length
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[TIME_WIDTH-1:0] == '0)
        else $error("zero_beat with nonzero beat length");

    // Output idle after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind midi_clock_tempo_meter mctm_checker #(
    .TIME_WIDTH (TIME_WIDTH)
) u_mctm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### test/midi_clock_tempo_meter_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the clock-pulse tempo meter: queued stimulus, clocked driver and monitor.
module midi_clock_tempo_meter_test;
    import mctm_pkg::*;

    localparam int TW            = 32;
    localparam int WIN           = 4;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int RANDOM_PULSES = 1850;
    localparam int REPORT_MAX    = 10;
    localparam int BIG_SEGMENT   = 25;

    typedef enum logic [1:0] {
        ACT_PULSE,
        ACT_CFG,
        ACT_PACE,
        ACT_DRAIN
    } t_act_kind;

    typedef enum logic [1:0] {
        PACE_SLOW_RX,
        PACE_SLOW_TX,
        PACE_FULL
    } t_pace;

    typedef struct packed {
        t_act_kind   kind;
        t_cfg_idx    idx;
        logic [31:0] value;
    } t_action;

    typedef struct packed {
        logic [TW-1:0]    beat_ticks;
        logic [MIT_W-1:0] tempo_bpm;
        logic             window_full;
        logic             zero_beat;
    } t_tempo_res;

    // DUT ports, all inputs known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [MIT_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;  // pulse_time
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;        // beat_ticks, tempo_bpm
    logic [1:0]           m_axis_tuser;        // window_full, zero_beat

    // Stimulus and scoreboard state
    t_action    action_q[$];
    t_tempo_res tempo_due[$];
    t_pace      pace          = PACE_SLOW_RX;
    logic       pulse_fire    = 1'b0;
    logic       cfg_fire      = 1'b0;
    int         quiet_cycles  = 0;
    int         bad_results   = 0;
    int         cycle_count   = 0;

    // Predictor state, reset values
    logic [PPB_W-1:0] ppb_reg      = PPB_RESET;
    logic [MIT_W-1:0] mit_reg      = MIT_RESET;
    logic [7:0]       pulse_cnt    = '0;
    logic [TW-1:0]    beat_start   = '0;
    logic [TW-1:0]    beat_window [WIN];
    int               beats_held   = 0;

    initial begin
        for (int i = 0; i < WIN; i++) beat_window[i] = '0;
    end

    midi_clock_tempo_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic queue_action(input t_act_kind kind, input t_cfg_idx idx,
                                input logic [31:0] value);
        t_action a;
        a.kind  = kind;
        a.idx   = idx;
        a.value = value;
        action_q.push_back(a);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [MIT_W-1:0] value);
        case (idx)
            CFG_PPB: ppb_reg = value[PPB_W-1:0];
            CFG_MIT: mit_reg = value;
            default: ;
        endcase
    endtask

    // One pulse: capture at count zero, measure at count pulses_per_beat
    task automatic predict_measurement(input logic [TW-1:0] now);
        logic [TW-1:0]   span;
        logic [TW+1:0]   span_sum;
        logic [TW-1:0]   avg;
        t_tempo_res      res;
        if (pulse_cnt == 8'd0) beat_start = now;
        if (pulse_cnt == ppb_reg) begin
            span = now - beat_start;
            if (beats_held < WIN) begin
                beat_window[beats_held] = span;
                beats_held++;
            end else begin
                for (int i = 0; i < WIN - 1; i++) beat_window[i] = beat_window[i+1];
                beat_window[WIN-1] = span;
            end
            res = '0;
            if (beats_held == WIN) begin
                span_sum = '0;
                for (int i = 0; i < WIN; i++) span_sum = span_sum + {2'b00, beat_window[i]};
                avg = span_sum[TW+1:2];
                res.beat_ticks = avg;
                if (avg == '0) begin
                    res.zero_beat = 1'b1;
                end else begin
                    res.tempo_bpm   = MIT_W'(mit_reg / avg);
                    res.window_full = 1'b1;
                end
            end
            tempo_due.push_back(res);
        end
        // wrap also covers a count left above a lowered register
        if (pulse_cnt >= ppb_reg) pulse_cnt = 8'd0;
        else pulse_cnt = pulse_cnt + 8'd1;
    endtask

    // Driver: next transfer offered at the falling edge
    always @(negedge i_clk) begin : driver
        t_action act;
        logic    holding_in;
        logic    holding_cfg;
        logic    next_tvalid;
        logic    next_cvalid;
        logic    busy;
        logic    tx_idle;
        holding_in  = s_axis_tvalid && !pulse_fire;
        holding_cfg = i_cfg_valid && !cfg_fire;
        next_tvalid = holding_in;
        next_cvalid = holding_cfg;
        busy        = holding_in || holding_cfg || !i_rst_n;
        while (!busy && action_q.size() > 0) begin
            act = action_q[0];
            case (act.kind)
                ACT_PACE: begin
                    pace = t_pace'(act.value[1:0]);
                    act  = action_q.pop_front();
                end
                ACT_DRAIN: begin
                    if (tempo_due.size() == 0) act = action_q.pop_front();
                    else busy = 1'b1;
                end
                ACT_CFG: begin
                    // register writes only while the block is idle
                    if (tempo_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                        next_cvalid = 1'b1;
                        i_cfg_index <= act.idx;
                        i_cfg_data  <= act.value[MIT_W-1:0];
                        act = action_q.pop_front();
                    end
                    busy = 1'b1;
                end
                default: begin
                    case (pace)
                        PACE_SLOW_RX: tx_idle = ($urandom_range(0, 99) < 29);
                        PACE_SLOW_TX: tx_idle = ($urandom_range(0, 99) < 77);
                        default:      tx_idle = 1'b0;
                    endcase
                    if (!tx_idle) begin
                        next_tvalid = 1'b1;
                        s_axis_tdata <= act.value;
                        act = action_q.pop_front();
                    end
                    busy = 1'b1;
                end
            endcase
        end
        s_axis_tvalid <= next_tvalid && i_rst_n;
        i_cfg_valid   <= next_cvalid && i_rst_n;
        case (pace)
            PACE_SLOW_RX: m_axis_tready <= ($urandom_range(0, 99) >= 77) && i_rst_n;
            PACE_SLOW_TX: m_axis_tready <= ($urandom_range(0, 99) >= 29) && i_rst_n;
            default:      m_axis_tready <= i_rst_n;
        endcase
    end

    // Monitor: transfers seen at the rising edge
    always @(posedge i_clk) begin : monitor
        t_tempo_res want;
        t_tempo_res got;
        if (!i_rst_n) begin
            pulse_fire   <= 1'b0;
            cfg_fire     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            pulse_fire <= s_axis_tvalid && s_axis_tready;
            cfg_fire   <= i_cfg_valid && o_cfg_ready;
            if (i_cfg_valid && o_cfg_ready) write_register(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) predict_measurement(s_axis_tdata[TW-1:0]);

            if (m_axis_tvalid && m_axis_tready) begin
                got.beat_ticks  = m_axis_tdata[TW-1:0];
                got.tempo_bpm   = m_axis_tdata[TW+MIT_W-1:TW];
                got.window_full = m_axis_tuser[0];
                got.zero_beat   = m_axis_tuser[1];
                if (tempo_due.size() == 0) begin
                    bad_results++;
                    if (bad_results <= REPORT_MAX)
                        $display("unexpected result: beat_ticks=%0d tempo_bpm=%0d full=%b zero=%b",
                                 got.beat_ticks, got.tempo_bpm, got.window_full, got.zero_beat);
                end else begin
                    want = tempo_due.pop_front();
                    if (got.beat_ticks !== want.beat_ticks || got.tempo_bpm !== want.tempo_bpm ||
                        got.window_full !== want.window_full ||
                        got.zero_beat !== want.zero_beat) begin
                        bad_results++;
                        if (bad_results <= REPORT_MAX)
                            $display("result mismatch: beat_ticks %0d/%0d tempo_bpm %0d/%0d full %b/%b zero %b/%b (exp/act)",
                                     want.beat_ticks, got.beat_ticks, want.tempo_bpm, got.tempo_bpm,
                                     want.window_full, got.window_full,
                                     want.zero_beat, got.zero_beat);
                    end
                end
            end

            // idle time since the last pulse or result transfer
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles < SETTLE_CYCLES)
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("midi_clock_tempo_meter_test: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] stamp;
        logic [31:0] step;
        logic [31:0] jitter;
        logic [31:0] minute;
        int          ppb;
        int          beats;
        int          n;
        int          drain_at;
        int          rnd_count;
        int          seg;
        t_pace       phase_now;
        t_pace       phase_planned;

        // Directed: one pulse per capture and one per measurement
        queue_action(ACT_CFG, CFG_PPB, 32'd1);
        queue_action(ACT_CFG, CFG_MIT, 32'h03FF_FFFF);
        // zero intervals while filling, then a zero average
        queue_action(ACT_PULSE, CFG_PPB, 32'h0000_0000);
        queue_action(ACT_PULSE, CFG_PPB, 32'h0000_0000);
        queue_action(ACT_PULSE, CFG_PPB, 32'h1234_5678);
        queue_action(ACT_PULSE, CFG_PPB, 32'h1234_5678);
        queue_action(ACT_PULSE, CFG_PPB, 32'hFFFF_FFFF);
        queue_action(ACT_PULSE, CFG_PPB, 32'hFFFF_FFFF);
        queue_action(ACT_PULSE, CFG_PPB, 32'hAAAA_AAAA);
        queue_action(ACT_PULSE, CFG_PPB, 32'hAAAA_AAAA);
        // interval across the timestamp wrap
        queue_action(ACT_PULSE, CFG_PPB, 32'hFFFF_FFF0);
        queue_action(ACT_PULSE, CFG_PPB, 32'h0000_0010);
        // largest interval fills the window
        for (int i = 0; i < WIN; i++) begin
            queue_action(ACT_PULSE, CFG_PPB, 32'h0000_0000);
            queue_action(ACT_PULSE, CFG_PPB, 32'hFFFF_FFFF);
        end
        // average of one tick: tempo equals the full dividend
        for (int i = 0; i < WIN; i++) begin
            queue_action(ACT_PULSE, CFG_PPB, 32'h5555_5555);
            queue_action(ACT_PULSE, CFG_PPB, 32'h5555_5556);
        end

        // Random segments: register setting, then beats with random timing
        stamp         = $urandom();
        rnd_count     = 0;
        seg           = 0;
        phase_planned = PACE_SLOW_RX;
        while (rnd_count < RANDOM_PULSES) begin
            if (rnd_count < RANDOM_PULSES / 3) phase_now = PACE_SLOW_RX;
            else if (rnd_count < 2 * RANDOM_PULSES / 3) phase_now = PACE_SLOW_TX;
            else phase_now = PACE_FULL;
            if (phase_now != phase_planned) begin
                queue_action(ACT_PACE, CFG_PPB, 32'(phase_now));
                phase_planned = phase_now;
            end

            case ($urandom_range(0, 19))
                0:       ppb = 0;
                1, 2, 3: ppb = $urandom_range(5, 12);
                default: ppb = $urandom_range(1, 4);
            endcase
            if (seg == BIG_SEGMENT) ppb = 255;
            queue_action(ACT_CFG, CFG_PPB, 32'(ppb));

            if (seg == 0 || $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 4))
                    0:       minute = 32'd1;
                    1:       minute = 32'd60000000;
                    2:       minute = 32'h03FF_FFFF;
                    3:       minute = 32'd60000;
                    default: minute = $urandom_range(1, 60000000);
                endcase
                queue_action(ACT_CFG, CFG_MIT, minute);
            end

            // pulse spacing and jitter mask
            case ($urandom_range(0, 4))
                0: begin step = 32'd0;                         jitter = 32'h0000_0001; end
                1: begin step = $urandom_range(1, 100);        jitter = 32'h0000_0003; end
                2: begin step = $urandom_range(1, 1 << 20);    jitter = 32'h0000_00FF; end
                3: begin step = $urandom();                    jitter = 32'hFFFF_FFFF; end
                default: begin step = $urandom_range(100, 30000); jitter = 32'h0000_0000; end
            endcase

            beats = (ppb == 255) ? 2 : $urandom_range(2, 10);
            // partial beat at the end leaves the count mid-cycle
            n = beats * (ppb + 1) + ((ppb == 255) ? 3 : $urandom_range(0, ppb));
            drain_at = (seg == 3 || $urandom_range(0, 7) == 0) ? n / 2 : -1;
            for (int k = 0; k < n; k++) begin
                if (k == drain_at) queue_action(ACT_DRAIN, CFG_PPB, 32'd0);
                stamp = stamp + step + ($urandom() & jitter);
                if ($urandom_range(0, 99) < 8) queue_action(ACT_PULSE, CFG_PPB, $urandom());
                else queue_action(ACT_PULSE, CFG_PPB, stamp);
            end
            rnd_count += n;
            seg++;
        end

        // Reset once, released on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all transfers and results, then let the block settle
        while (action_q.size() != 0 || s_axis_tvalid || i_cfg_valid || tempo_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (bad_results == 0) begin
            $display("midi_clock_tempo_meter_test: PASS");
        end else begin
            $display("midi_clock_tempo_meter_test: FAIL");
        end
        $finish;
    end

endmodule
